>>> rtl/u2c_pkg.sv
// Shared types, status codes and the code point table for the UTF-8 to CP1251 transcoder.
// No dependencies; imported by the decoder, the top level, the checker and the testbench.
`default_nettype none

package u2c_pkg;

    localparam logic [1:0] ST_CHAR = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    // Per-string decode state
    typedef struct packed {
        logic       lead_pending;
        logic [4:0] lead_bits;
        logic       string_failed;
    } dec_state_t;

    // One decoded transaction, if any
    typedef struct packed {
        logic       has_result;
        logic [7:0] out_byte;
        logic [1:0] status;
    } dec_result_t;

    // Reverse table for code points outside the linear ranges.
    // Entries above 0x7FF can never be formed from a two-byte sequence.
    // Returns {hit, byte}.
    function automatic logic [8:0] map_lookup(input logic [10:0] cp);
        logic [8:0] res;
        case (cp)
            11'h453: res = {1'b1, 8'h83};
            11'h409: res = {1'b1, 8'h8A};
            11'h40A: res = {1'b1, 8'h8C};
            11'h40C: res = {1'b1, 8'h8D};
            11'h40B: res = {1'b1, 8'h8E};
            11'h40F: res = {1'b1, 8'h8F};
            11'h452: res = {1'b1, 8'h90};
            11'h459: res = {1'b1, 8'h9A};
            11'h45A: res = {1'b1, 8'h9C};
            11'h45C: res = {1'b1, 8'h9D};
            11'h45B: res = {1'b1, 8'h9E};
            11'h45F: res = {1'b1, 8'h9F};
            11'h40E: res = {1'b1, 8'hA1};
            11'h45E: res = {1'b1, 8'hA2};
            11'h408: res = {1'b1, 8'hA3};
            11'h490: res = {1'b1, 8'hA5};
            11'h401: res = {1'b1, 8'hA8};
            11'h404: res = {1'b1, 8'hAA};
            11'h407: res = {1'b1, 8'hAF};
            11'h406: res = {1'b1, 8'hB2};
            11'h456: res = {1'b1, 8'hB3};
            11'h491: res = {1'b1, 8'hB4};
            11'h451: res = {1'b1, 8'hB8};
            11'h454: res = {1'b1, 8'hBA};
            11'h458: res = {1'b1, 8'hBC};
            11'h405: res = {1'b1, 8'hBD};
            11'h455: res = {1'b1, 8'hBE};
            11'h457: res = {1'b1, 8'hBF};
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/utf8_to_cp1251_transcoder_top.sv
// UTF-8 to Windows-1251 transcoder, top level: input register, decoder, result register.
// Depends on u2c_pkg and u2c_decode.
`default_nettype none

// Takes one UTF-8 byte per cycle and returns Windows-1251 characters; a zero
// byte ends the string and yields an end status, or cannot-convert when a
// lead byte was still pending. After a conversion failure, bytes and the
// terminator are dropped silently. A byte is accepted every cycle as long as
// results are taken; a byte is held in the input register and its result in
// the result register around the decoder, and a byte that yields a result
// waits while the result register holds one not yet taken.
// Lead bytes and dropped bytes produce no result transaction.
module utf8_to_cp1251_transcoder_top
    import u2c_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      status
);

    logic        in_vld_reg;
    logic [7:0]  byte_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t dec_res;
    logic        out_vld_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  status_reg;
    logic        advance;

    u2c_decode u_decode (
        .in_byte (byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (dec_res)
    );

    // Held byte moves on when its result, if any, has a free slot
    assign advance  = in_vld_reg && (!dec_res.has_result || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= in_byte;
    end

    // String state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && dec_res.has_result)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec_res.has_result)
        begin
            out_byte_reg <= dec_res.out_byte;
            status_reg   <= dec_res.status;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

>>> rtl/u2c_decode.sv
// Combinational byte decoder: current string state plus one byte gives the
// next state and at most one result. Depends on u2c_pkg.
`default_nettype none

module u2c_decode
    import u2c_pkg::*;
(
    input  wire logic [7:0]  in_byte,
    input  wire dec_state_t  cur,
    output dec_state_t       nxt,
    output dec_result_t      res
);

    logic [10:0] cp;
    logic [10:0] cp_cyr;
    logic [10:0] cp_sym;
    logic [8:0]  lut;

    assign cp     = {cur.lead_bits, in_byte[5:0]};
    assign cp_cyr = cp - 11'h350;
    assign cp_sym = cp - 11'h382;
    assign lut    = map_lookup(cp);

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (in_byte == 8'd0)
        begin
            // terminator: clear state, report unless already aborted
            nxt = '0;
            if (!cur.string_failed)
            begin
                res.has_result = 1'b1;
                res.status     = cur.lead_pending ? ST_FAIL : ST_END;
            end
        end
        else if (cur.string_failed)
        begin
            // swallow until terminator
        end
        else if (cur.lead_pending)
        begin
            // second byte completes the code point
            nxt.lead_pending = 1'b0;
            nxt.lead_bits    = '0;
            res.has_result   = 1'b1;
            res.status       = ST_CHAR;
            if (cp >= 11'h410 && cp <= 11'h44F)
                res.out_byte = cp_cyr[7:0];
            else if (cp >= 11'h080 && cp <= 11'h0FF)
                res.out_byte = cp[7:0];
            else if (cp >= 11'h402 && cp <= 11'h403)
                res.out_byte = cp_sym[7:0];
            else if (lut[8])
                res.out_byte = lut[7:0];
            else
            begin
                nxt.string_failed = 1'b1;
                res.status        = ST_FAIL;
            end
        end
        else if (!in_byte[7])
        begin
            res.has_result = 1'b1;
            res.out_byte   = in_byte;
            res.status     = ST_CHAR;
        end
        else if (!in_byte[5])
        begin
            // lead byte: hold it, no result yet
            nxt.lead_pending = 1'b1;
            nxt.lead_bits    = in_byte[4:0];
        end
        else
        begin
            nxt.string_failed = 1'b1;
            res.has_result    = 1'b1;
            res.status        = ST_FAIL;
        end
    end

endmodule

`default_nettype wire

>>> rtl/u2c_checker.sv
// Port-level checks for the transcoder top level, bound to every instance.
// Depends on u2c_pkg and utf8_to_cp1251_transcoder_top.
`default_nettype none

module u2c_checker
    import u2c_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] status
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
        else $error("result changed while stalled");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_CHAR || status == ST_END || status == ST_FAIL))
        else $error("undefined status code");

    // Non-character results carry a zero byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_CHAR |-> out_byte == 8'd0)
        else $error("nonzero byte on end or failure result");

    // With the result slot empty the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

endmodule

bind utf8_to_cp1251_transcoder_top u2c_checker u_u2c_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .status    (status)
);

`default_nettype wire

>>> sim/tb_utf8_to_cp1251_transcoder_top.sv
// Testbench for utf8_to_cp1251_transcoder_top: drives UTF-8 byte strings and checks
// the CP1251 characters and status codes against a cycle-free predictor.
// Depends on u2c_pkg (status codes) and the transcoder RTL.
`timescale 1ns / 1ps

module tb_utf8_to_cp1251_transcoder_top;
    import u2c_pkg::*;

    localparam int STRING_BYTES = 1950;
    localparam int CALM_TAIL    = 300;

    typedef struct packed {
        logic [7:0] chr;
        logic [1:0] st;
    } cp1251_item_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [1:0] status;

    // Stimulus and expectations
    logic [7:0]   utf8_bytes_q[$];
    cp1251_item_t cp1251_expect_q[$];
    cp1251_item_t want;
    int           fail_cnt = 0;

    // Predictor state for the string in flight
    logic       lead_pend  = 1'b0;
    logic [4:0] lead_hi    = 5'd0;
    logic       str_failed = 1'b0;

    // Flow control
    logic       calm    = 1'b0;
    logic       hold_rx = 1'b0;
    logic [2:0] tx_gap  = 3'd0;
    logic [2:0] rx_gap  = 3'd0;

    utf8_to_cp1251_transcoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .status    (status)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Code point to CP1251; returns {hit, char}
    function automatic logic [8:0] cp1251_of(input logic [10:0] cp);
        logic [10:0] d;
        logic [8:0]  res;
        res = 9'd0;
        if (cp >= 11'h410 && cp <= 11'h44F)
        begin
            d   = cp - 11'h350;
            res = {1'b1, d[7:0]};
        end
        else if (cp >= 11'h080 && cp <= 11'h0FF)
            res = {1'b1, cp[7:0]};
        else if (cp >= 11'h402 && cp <= 11'h403)
        begin
            d   = cp - 11'h382;
            res = {1'b1, d[7:0]};
        end
        else
        begin
            // Scattered Cyrillic letters outside the linear block
            case (cp)
                11'h453: res = {1'b1, 8'h83};
                11'h409: res = {1'b1, 8'h8A};
                11'h40A: res = {1'b1, 8'h8C};
                11'h40C: res = {1'b1, 8'h8D};
                11'h40B: res = {1'b1, 8'h8E};
                11'h40F: res = {1'b1, 8'h8F};
                11'h452: res = {1'b1, 8'h90};
                11'h459: res = {1'b1, 8'h9A};
                11'h45A: res = {1'b1, 8'h9C};
                11'h45C: res = {1'b1, 8'h9D};
                11'h45B: res = {1'b1, 8'h9E};
                11'h45F: res = {1'b1, 8'h9F};
                11'h40E: res = {1'b1, 8'hA1};
                11'h45E: res = {1'b1, 8'hA2};
                11'h408: res = {1'b1, 8'hA3};
                11'h490: res = {1'b1, 8'hA5};
                11'h401: res = {1'b1, 8'hA8};
                11'h404: res = {1'b1, 8'hAA};
                11'h407: res = {1'b1, 8'hAF};
                11'h406: res = {1'b1, 8'hB2};
                11'h456: res = {1'b1, 8'hB3};
                11'h491: res = {1'b1, 8'hB4};
                11'h451: res = {1'b1, 8'hB8};
                11'h454: res = {1'b1, 8'hBA};
                11'h458: res = {1'b1, 8'hBC};
                11'h405: res = {1'b1, 8'hBD};
                11'h455: res = {1'b1, 8'hBE};
                11'h457: res = {1'b1, 8'hBF};
                default: res = 9'd0;
            endcase
        end
        return res;
    endfunction

    // Advance the string state by one byte and queue the character it yields
    task automatic transcode_byte(input logic [7:0] b);
        logic [10:0] cp;
        logic [8:0]  hit;
        if (b == 8'h00)
        begin
            // terminator: silent after an abort, fail if a lead is dangling
            if (!str_failed)
                cp1251_expect_q.push_back('{8'h00, lead_pend ? ST_FAIL : ST_END});
            lead_pend  = 1'b0;
            lead_hi    = 5'd0;
            str_failed = 1'b0;
        end
        else if (!str_failed)
        begin
            if (lead_pend)
            begin
                // suffix is taken as is, even ASCII
                cp        = {lead_hi, b[5:0]};
                lead_pend = 1'b0;
                lead_hi   = 5'd0;
                hit       = cp1251_of(cp);
                if (hit[8])
                    cp1251_expect_q.push_back('{hit[7:0], ST_CHAR});
                else
                begin
                    str_failed = 1'b1;
                    cp1251_expect_q.push_back('{8'h00, ST_FAIL});
                end
            end
            else if (!b[7])
                cp1251_expect_q.push_back('{b, ST_CHAR});
            else if (!b[5])
            begin
                lead_pend = 1'b1;
                lead_hi   = b[4:0];
            end
            else
            begin
                str_failed = 1'b1;
                cp1251_expect_q.push_back('{8'h00, ST_FAIL});
            end
        end
    endtask

    task automatic push_point(input logic [10:0] cp);
        utf8_bytes_q.push_back({3'b110, cp[10:6]});
        utf8_bytes_q.push_back({2'b10, cp[5:0]});
    endtask

    // Byte driver: predicts on each accepted transaction, then offers the next byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            tx_gap   <= 3'd0;
            calm     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                transcode_byte(in_byte);
            calm <= (utf8_bytes_q.size() < CALM_TAIL);
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 3'd0)
                begin
                    tx_gap   <= tx_gap - 3'd1;
                    in_valid <= 1'b0;
                end
                else if (!calm && !hold_rx && $urandom_range(0, 9) == 0)
                begin
                    tx_gap   <= 3'($urandom_range(0, 6));
                    in_valid <= 1'b0;
                end
                else if (utf8_bytes_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= utf8_bytes_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result sink: random stall bursts plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap    <= 3'd0;
        end
        else if (hold_rx)
            out_ready <= 1'b0;
        else if (rx_gap != 3'd0)
        begin
            rx_gap    <= rx_gap - 3'd1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            rx_gap    <= 3'($urandom_range(0, 6));
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: compare each result transaction with the oldest expected character
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (cp1251_expect_q.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected result, expected none, got char=%h status=%0d",
                         $time, out_byte, status);
            end
            else
            begin
                want = cp1251_expect_q.pop_front();
                if (out_byte !== want.chr || status !== want.st)
                begin
                    fail_cnt++;
                    $display("%0t: mismatch, expected char=%h status=%0d, got char=%h status=%0d",
                             $time, want.chr, want.st, out_byte, status);
                end
            end
        end
    end

    // Long receiver hold-off while bytes keep coming, to back up the pipeline
    initial
    begin
        @(posedge rst_n);
        repeat (200) @(posedge clk);
        hold_rx <= 1'b1;
        repeat (64) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus build, reset and end of run
    initial
    begin
        int          r;
        int          nch;
        logic [10:0] cp;

        // Directed: ASCII extremes, range edges, table hit, string end,
        // table miss then swallowed bytes, lead with bit 5 set,
        // terminator on a dangling lead, ASCII used as suffix
        utf8_bytes_q = '{8'h41, 8'h7F, 8'h01, 8'hD0, 8'h90, 8'hD1, 8'h8F,
                         8'hC2, 8'h80, 8'hC3, 8'hBF, 8'hD0, 8'h82, 8'hD2, 8'h90, 8'h00,
                         8'hD0, 8'h80, 8'h41, 8'h00,
                         8'hFF, 8'h00,
                         8'hC2, 8'h00,
                         8'hC2, 8'h41, 8'h00};

        // Random strings: mostly well-formed, with some noise and truncation
        while (utf8_bytes_q.size() < STRING_BYTES)
        begin
            nch = $urandom_range(0, 10);
            for (int i = 0; i < nch; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    utf8_bytes_q.push_back(8'($urandom_range(1, 127)));
                else if (r < 65)
                    push_point(11'(11'h410 + $urandom_range(0, 63)));
                else if (r < 75)
                    push_point(11'(11'h080 + $urandom_range(0, 127)));
                else if (r < 88)
                    push_point(11'(($urandom_range(0, 1) ? 11'h450 : 11'h400)
                                   + $urandom_range(0, 15)));
                else if (r < 91)
                    push_point(11'(11'h490 + $urandom_range(0, 1)));
                else if (r < 95)
                begin
                    cp = 11'($urandom_range(0, 2047));
                    push_point(cp);
                end
                else if (r < 98)
                    utf8_bytes_q.push_back(8'($urandom_range(1, 255)));
                else
                begin
                    utf8_bytes_q.push_back(8'(8'h80 | $urandom_range(0, 31)));
                    utf8_bytes_q.push_back(8'($urandom_range(1, 255)));
                end
            end
            if ($urandom_range(0, 9) == 0)
                utf8_bytes_q.push_back(8'(8'hC0 | $urandom_range(0, 31)));
            utf8_bytes_q.push_back(8'h00);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all bytes taken, all results returned
        while (utf8_bytes_q.size() != 0 || in_valid || cp1251_expect_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
